FILE: design/bbl_pkg.sv
package bbl_pkg;

   // default geometry
   localparam int DEF_SLOTS     = 16;
   localparam int DEF_KEY_BITS  = 16;
   localparam int DEF_SIZE_BITS = 24;

   // field widths fixed by the interface
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int TOTAL_W  = 32;

   // request commands
   localparam logic [CMD_W-1:0] CMD_ENSURE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // final status codes
   localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LOADED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LOAD_FAIL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd5;

   // result kinds
   localparam logic KIND_NOTICE = 1'b0;
   localparam logic KIND_FINAL  = 1'b1;

endpackage

FILE: design/bbl_slot_ram.sv
module bbl_slot_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 44
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bbl_notice_fifo.sv
module bbl_notice_fifo #(
   parameter int DEPTH = 16,
   parameter int KW    = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          push,
   input  logic [KW-1:0] push_key,
   input  logic          pop,
   output logic          empty,
   output logic [KW-1:0] head_key
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = $clog2(DEPTH + 1);

   logic [KW-1:0] keys_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;

   // pointers restart with every request
   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (clear) begin
         wp_in = '0;
         rp_in = '0;
      end else begin
         if (push) wp_in = wp_ff + PW'(1);
         if (pop)  rp_in = rp_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   // evicted key storage
   always_ff @(posedge clock) begin
      if (push && !clear) begin
         keys_ff[wp_ff[IW-1:0]] <= push_key;
      end
   end

   assign empty    = (wp_ff == rp_ff);
   assign head_key = keys_ff[rp_ff[IW-1:0]];

endmodule

FILE: design/byte_budget_lru_cache_unit.sv
// Size-aware LRU cache of up to SLOTS keys with a byte budget. A request is
// taken when req_valid is high and req_stall low; the unit then works on it
// alone, holding req_stall until every result has been loaded. Key, size and
// recency rank of each slot sit in one single-port-read RAM, and every pass
// over the table is a sweep of all slots (one slot read per cycle, written
// back where it changes). A query, a failed load or a remove of an absent key
// takes one lookup sweep; a hit adds a touch sweep; a remove adds a drop
// sweep; a load adds an insert sweep, a drop sweep if the table is full, and
// a find plus a drop sweep for each budget eviction. Results then leave one
// per cycle while rsp_stall is low: eviction notices first, then the final
// status, all carrying the totals after the request.
// csr_ready is always high; write capacity only while the unit is idle.
module byte_budget_lru_cache_unit #(
   parameter int SLOTS     = bbl_pkg::DEF_SLOTS,
   parameter int KEY_BITS  = bbl_pkg::DEF_KEY_BITS,
   parameter int SIZE_BITS = bbl_pkg::DEF_SIZE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bbl_pkg::CMD_W-1:0]    req_cmd,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic                         req_load_ok,
   input  logic [SIZE_BITS-1:0]         req_load_bytes,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [bbl_pkg::STATUS_W-1:0] rsp_status,
   output logic [KEY_BITS-1:0]          rsp_result_key,
   output logic                         rsp_is_resident,
   output logic [bbl_pkg::TOTAL_W-1:0]  rsp_total_bytes,
   output logic [bbl_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bbl_pkg::TOTAL_W-1:0]  csr_data
);
   import bbl_pkg::*;

   localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int NW   = $clog2(SLOTS + 2);
   localparam int TW   = SIZE_BITS + CW;
   localparam int DW   = KEY_BITS + SIZE_BITS + AW;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOOK  = 4'd1;
   localparam logic [3:0] S_DROP  = 4'd2;
   localparam logic [3:0] S_INS   = 4'd3;
   localparam logic [3:0] S_CHECK = 4'd4;
   localparam logic [3:0] S_FIND  = 4'd5;
   localparam logic [3:0] S_TOUCH = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   localparam logic [1:0] AFT_INS   = 2'd0;
   localparam logic [1:0] AFT_CHECK = 2'd1;
   localparam logic [1:0] AFT_OUT   = 2'd2;

   logic [3:0]           state_ff, state_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic                 ok_ff, ok_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 hit_ff, hit_in;
   logic [AW-1:0]        s_ff, s_in;
   logic [AW-1:0]        rs_ff, rs_in;
   logic [SIZE_BITS-1:0] msize_ff, msize_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        tgt_ff, tgt_in;
   logic [AW-1:0]        trank_ff, trank_in;
   logic [SIZE_BITS-1:0] tsize_ff, tsize_in;
   logic [KEY_BITS-1:0]  tkey_ff, tkey_in;
   logic                 placed_ff, placed_in;
   logic [1:0]           after_ff, after_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 res_ff, res_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [TW-1:0]        total_ff, total_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [TOTAL_W-1:0]   cap_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]  rsp_key_ff, rsp_key_in;
   logic                 rsp_res_ff, rsp_res_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, p;
   logic [DW-1:0]        rd_data, wr_data;
   logic [KEY_BITS-1:0]  r_key;
   logic [SIZE_BITS-1:0] r_size;
   logic [AW-1:0]        r_rank;
   logic                 sweep, proc, sweep_end, v_p, oldest_p;
   logic                 fifo_clear, fifo_push, fifo_pop, fifo_empty;
   logic [KEY_BITS-1:0]  fifo_push_key, fifo_head;
   logic [63:0]          total64;
   logic [31:0]          count32;
   logic [NW-1:0]        cnt_m1;

   // slot table and eviction notice queue
   bbl_slot_ram #(.DEPTH(SLOTS), .AW(AW), .DW(DW)) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (p),
      .wr_data (wr_data)
   );

   bbl_notice_fifo #(.DEPTH(SLOTS), .KW(KEY_BITS)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .clear    (fifo_clear),
      .push     (fifo_push),
      .push_key (fifo_push_key),
      .pop      (fifo_pop),
      .empty    (fifo_empty),
      .head_key (fifo_head)
   );

   // sweep bookkeeping: read slot cnt, process slot cnt-1
   assign sweep = (state_ff == S_LOOK) || (state_ff == S_DROP) || (state_ff == S_INS) ||
                  (state_ff == S_FIND) || (state_ff == S_TOUCH);
   assign rd_en     = sweep && (cnt_ff < NW'(SLOTS));
   assign rd_addr   = cnt_ff[AW-1:0];
   assign cnt_m1    = cnt_ff - NW'(1);
   assign p         = cnt_m1[AW-1:0];
   assign proc      = sweep && (cnt_ff != '0) && (cnt_ff <= NW'(SLOTS));
   assign sweep_end = sweep && (cnt_ff == NW'(SLOTS + 1));
   assign r_key     = rd_data[DW-1 -: KEY_BITS];
   assign r_size    = rd_data[AW +: SIZE_BITS];
   assign r_rank    = rd_data[AW-1:0];
   assign v_p       = valid_ff[p];
   assign oldest_p  = v_p && ((CW'(r_rank) + CW'(1)) == count_ff);

   // widened totals, saturated when the result is built
   assign total64 = 64'(total_ff);
   assign count32 = 32'(count_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      ok_in     = ok_ff;
      size_in   = size_ff;
      hit_in    = hit_ff;
      s_in      = s_ff;
      rs_in     = rs_ff;
      msize_in  = msize_ff;
      found_in  = found_ff;
      tgt_in    = tgt_ff;
      trank_in  = trank_ff;
      tsize_in  = tsize_ff;
      tkey_in   = tkey_ff;
      placed_in = placed_ff;
      after_in  = after_ff;
      status_in = status_ff;
      res_in    = res_ff;
      valid_in  = valid_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_data       = rd_data;
      fifo_clear    = 1'b0;
      fifo_push     = 1'b0;
      fifo_push_key = tkey_ff;
      fifo_pop      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (sweep) cnt_in = sweep_end ? '0 : cnt_ff + NW'(1);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               key_in     = req_key;
               ok_in      = req_load_ok;
               size_in    = req_load_bytes;
               hit_in     = 1'b0;
               found_in   = 1'b0;
               placed_in  = 1'b0;
               fifo_clear = 1'b1;
               cnt_in     = '0;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            if (proc) begin
               if (v_p && (r_key == key_ff)) begin
                  hit_in   = 1'b1;
                  s_in     = p;
                  rs_in    = r_rank;
                  msize_in = r_size;
               end
               if (oldest_p) begin
                  tgt_in   = p;
                  trank_in = r_rank;
                  tsize_in = r_size;
                  tkey_in  = r_key;
               end
            end
            if (sweep_end) begin
               case (cmd_ff)
                  CMD_ENSURE: begin
                     if (hit_ff) begin
                        state_in = S_TOUCH;
                     end else if (!ok_ff) begin
                        status_in = ST_LOAD_FAIL;
                        res_in    = 1'b0;
                        state_in  = S_OUT;
                     end else if (count_ff == CW'(SLOTS)) begin
                        fifo_push = 1'b1;
                        after_in  = AFT_INS;
                        state_in  = S_DROP;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  CMD_REMOVE: begin
                     res_in = 1'b0;
                     if (hit_ff) begin
                        tgt_in    = s_ff;
                        trank_in  = rs_ff;
                        tsize_in  = msize_ff;
                        status_in = ST_REMOVED;
                        after_in  = AFT_OUT;
                        state_in  = S_DROP;
                     end else begin
                        status_in = ST_NOT_PRESENT;
                        state_in  = S_OUT;
                     end
                  end
                  default: begin
                     status_in = hit_ff ? ST_PRESENT : ST_NOT_PRESENT;
                     res_in    = hit_ff;
                     state_in  = S_OUT;
                  end
               endcase
            end
         end
         S_DROP: begin
            // close the gap left by the dropped rank
            if (proc && v_p && (r_rank > trank_ff)) begin
               wr_en   = 1'b1;
               wr_data = {r_key, r_size, r_rank - AW'(1)};
            end
            if (sweep_end) begin
               valid_in[tgt_ff] = 1'b0;
               total_in = total_ff - TW'(tsize_ff);
               count_in = count_ff - CW'(1);
               case (after_ff)
                  AFT_INS:   state_in = S_INS;
                  AFT_CHECK: state_in = S_CHECK;
                  default:   state_in = S_OUT;
               endcase
            end
         end
         S_INS: begin
            // age every resident entry, place the new one in the first free slot
            if (proc) begin
               if (v_p) begin
                  wr_en   = 1'b1;
                  wr_data = {r_key, r_size, r_rank + AW'(1)};
               end else if (!placed_in) begin
                  wr_en       = 1'b1;
                  wr_data     = {key_ff, size_ff, AW'(0)};
                  valid_in[p] = 1'b1;
                  placed_in   = 1'b1;
                  s_in        = p;
               end
            end
            if (sweep_end) begin
               if (placed_ff) begin
                  total_in = total_ff + TW'(size_ff);
                  count_in = count_ff + CW'(1);
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ((count_ff != '0) && (64'(total_ff) > 64'(cap_ff))) begin
               found_in = 1'b0;
               state_in = S_FIND;
            end else begin
               status_in = ST_LOADED;
               res_in    = placed_ff && valid_ff[s_ff];
               state_in  = S_OUT;
            end
         end
         S_FIND: begin
            if (proc && oldest_p) begin
               found_in = 1'b1;
               tgt_in   = p;
               trank_in = r_rank;
               tsize_in = r_size;
               tkey_in  = r_key;
            end
            if (sweep_end) begin
               if (found_ff) begin
                  fifo_push = !(placed_ff && (tgt_ff == s_ff));
                  after_in  = AFT_CHECK;
                  state_in  = S_DROP;
               end else begin
                  status_in = ST_LOADED;
                  res_in    = placed_ff && valid_ff[s_ff];
                  state_in  = S_OUT;
               end
            end
         end
         S_TOUCH: begin
            // move the hit entry to the front
            if (proc) begin
               if (p == s_ff) begin
                  wr_en   = 1'b1;
                  wr_data = {r_key, r_size, AW'(0)};
               end else if (v_p && (r_rank < rs_ff)) begin
                  wr_en   = 1'b1;
                  wr_data = {r_key, r_size, r_rank + AW'(1)};
               end
            end
            if (sweep_end) begin
               status_in = ST_HIT;
               res_in    = 1'b1;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            // notices first, then the final status
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = (|total64[63:32]) ? '1 : total64[31:0];
               rsp_count_in = count32[COUNT_W-1:0];
               if (!fifo_empty) begin
                  fifo_pop      = 1'b1;
                  rsp_kind_in   = KIND_NOTICE;
                  rsp_status_in = ST_HIT;
                  rsp_key_in    = fifo_head;
                  rsp_res_in    = 1'b0;
                  rsp_last_in   = 1'b0;
               end else begin
                  rsp_kind_in   = KIND_FINAL;
                  rsp_status_in = status_ff;
                  rsp_key_in    = key_ff;
                  rsp_res_in    = res_ff;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         found_ff     <= 1'b0;
         placed_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         found_ff     <= found_in;
         placed_ff    <= placed_in;
         if (csr_valid && csr_ready) cap_ff <= csr_data;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      ok_ff         <= ok_in;
      size_ff       <= size_in;
      s_ff          <= s_in;
      rs_ff         <= rs_in;
      msize_ff      <= msize_in;
      tgt_ff        <= tgt_in;
      trank_ff      <= trank_in;
      tsize_ff      <= tsize_in;
      tkey_ff       <= tkey_in;
      after_ff      <= after_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_key  = rsp_key_ff;
   assign rsp_is_resident = rsp_res_ff;
   assign rsp_total_bytes = rsp_total_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("resident count above slot count");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == int'(count_ff)))
      else $error("resident count disagrees with valid bits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff &&
         $stable({rsp_kind_ff, rsp_status_ff, rsp_key_ff, rsp_res_ff,
                  rsp_total_ff, rsp_count_ff, rsp_last_ff})))
      else $error("stalled result changed");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bbl_pkg::*;

   localparam int SLOTS  = DEF_SLOTS;
   localparam int KEY_W  = DEF_KEY_BITS;
   localparam int SIZE_W = DEF_SIZE_BITS;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic              load_ok;
      logic [SIZE_W-1:0] load_bytes;
   } request_type;

   typedef struct packed {
      logic                kind;
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    result_key;
      logic                is_resident;
      logic [TOTAL_W-1:0]  total_bytes;
      logic [COUNT_W-1:0]  entry_count;
      logic                last;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [KEY_W-1:0]    req_key;
   logic                req_load_ok;
   logic [SIZE_W-1:0]   req_load_bytes;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_kind;
   logic [STATUS_W-1:0] rsp_status;
   logic [KEY_W-1:0]    rsp_result_key;
   logic                rsp_is_resident;
   logic [TOTAL_W-1:0]  rsp_total_bytes;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                rsp_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [TOTAL_W-1:0]  csr_data;

   byte_budget_lru_cache_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_key(req_key), .req_load_ok(req_load_ok), .req_load_bytes(req_load_bytes),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_status(rsp_status), .rsp_result_key(rsp_result_key),
      .rsp_is_resident(rsp_is_resident), .rsp_total_bytes(rsp_total_bytes),
      .rsp_entry_count(rsp_entry_count), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // shadow cache state
   logic [KEY_W-1:0]   shadow_key [SLOTS];
   logic               shadow_valid [SLOTS];
   logic [SIZE_W-1:0]  shadow_size [SLOTS];
   int                 shadow_rank [SLOTS];
   logic [63:0]        shadow_total;
   int                 shadow_count;
   logic [TOTAL_W-1:0] budget;

   request_type pending_requests[$];
   outcome_type expected_outcomes[$];
   int          fail_count;
   bit          idle_enable;
   bit          sender_hold;
   bit          req_taken;
   int          rsp_hold_cycles;

   function automatic int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int find_eldest();
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_rank[i] + 1 == shadow_count) return i;
      return -1;
   endfunction

   function automatic void evict_slot(int s);
      int r;
      r = shadow_rank[s];
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
      shadow_valid[s] = 1'b0;
      shadow_total -= shadow_size[s];
      shadow_count--;
   endfunction

   // work out the results one request causes and queue them
   function automatic void predict_request(request_type rq);
      int                  s, v, free_slot;
      logic [STATUS_W-1:0] st;
      bit                  res;
      logic [KEY_W-1:0]    notices[$];
      outcome_type         o;
      s = find_slot(rq.key);
      if (rq.cmd == CMD_ENSURE) begin
         if (s >= 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (shadow_valid[i] && shadow_rank[i] < shadow_rank[s]) shadow_rank[i]++;
            shadow_rank[s] = 0;
            st = ST_HIT;
            res = 1;
         end else if (!rq.load_ok) begin
            st = ST_LOAD_FAIL;
            res = 0;
         end else begin
            if (shadow_count >= SLOTS) begin
               v = find_eldest();
               if (v >= 0) begin
                  notices.push_back(shadow_key[v]);
                  evict_slot(v);
               end
            end
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!shadow_valid[i]) free_slot = i;
            if (free_slot >= 0) begin
               for (int j = 0; j < SLOTS; j++)
                  if (shadow_valid[j]) shadow_rank[j]++;
               shadow_valid[free_slot] = 1'b1;
               shadow_key[free_slot] = rq.key;
               shadow_size[free_slot] = rq.load_bytes;
               shadow_rank[free_slot] = 0;
               shadow_total += rq.load_bytes;
               shadow_count++;
               s = free_slot;
            end
            while (shadow_count > 0 && shadow_total > {32'd0, budget}) begin
               v = find_eldest();
               if (v < 0) break;
               if (v != s) notices.push_back(shadow_key[v]);
               evict_slot(v);
            end
            st = ST_LOADED;
            res = find_slot(rq.key) >= 0;
         end
      end else if (rq.cmd == CMD_REMOVE) begin
         if (s >= 0) begin
            evict_slot(s);
            st = ST_REMOVED;
         end else st = ST_NOT_PRESENT;
         res = 0;
      end else begin
         st = (s >= 0) ? ST_PRESENT : ST_NOT_PRESENT;
         res = s >= 0;
      end
      o.total_bytes = (shadow_total > 64'hFFFF_FFFF) ? '1 : shadow_total[31:0];
      o.entry_count = shadow_count[COUNT_W-1:0];
      foreach (notices[i]) begin
         o.kind = KIND_NOTICE;
         o.status = '0;
         o.result_key = notices[i];
         o.is_resident = 0;
         o.last = 0;
         expected_outcomes.push_back(o);
      end
      o.kind = KIND_FINAL;
      o.status = st;
      o.result_key = rq.key;
      o.is_resident = res;
      o.last = 1;
      expected_outcomes.push_back(o);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // request driver: a request offered stays until it has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_taken) begin
         req_taken = 0;
         if (pending_requests.size() > 0 && !sender_hold &&
             !(idle_enable && $urandom_range(99) < 34)) begin
            request_type rq;
            rq = pending_requests.pop_front();
            req_valid <= 1;
            req_cmd <= rq.cmd;
            req_key <= rq.key;
            req_load_ok <= rq.load_ok;
            req_load_bytes <= rq.load_bytes;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // accepted requests feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         request_type rq;
         rq.cmd = req_cmd;
         rq.key = req_key;
         rq.load_ok = req_load_ok;
         rq.load_bytes = req_load_bytes;
         req_taken = 1;
         predict_request(rq);
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(99) < 34);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result key %0h", rsp_result_key);
            fail_count++;
         end else begin
            outcome_type e;
            e = expected_outcomes.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind exp %0h got %0h", e.kind, rsp_kind); fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0h got %0h", e.status, rsp_status); fail_count++;
            end
            if (rsp_result_key !== e.result_key) begin
               $error("result_key exp %0h got %0h", e.result_key, rsp_result_key);
               fail_count++;
            end
            if (rsp_is_resident !== e.is_resident) begin
               $error("is_resident exp %0h got %0h", e.is_resident, rsp_is_resident);
               fail_count++;
            end
            if (rsp_total_bytes !== e.total_bytes) begin
               $error("total_bytes exp %0h got %0h", e.total_bytes, rsp_total_bytes);
               fail_count++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $error("entry_count exp %0d got %0d", e.entry_count, rsp_entry_count);
               fail_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0h got %0h", e.last, rsp_last); fail_count++;
            end
         end
      end
   end

   task automatic add_request(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic ok,
                              logic [SIZE_W-1:0] b);
      request_type rq;
      rq.cmd = c; rq.key = k; rq.load_ok = ok; rq.load_bytes = b;
      pending_requests.push_back(rq);
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // capacity write while idle
   task automatic set_budget(logic [TOTAL_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      budget = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // small key pool so hits, removes and evictions happen often
   function automatic logic [KEY_W-1:0] pick_key();
      return ($urandom_range(9) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(23));
   endfunction

   task automatic add_random(int n, int size_max);
      logic [CMD_W-1:0] c;
      for (int i = 0; i < n; i++) begin
         c = ($urandom_range(9) < 6) ? CMD_ENSURE : CMD_W'($urandom_range(3));
         add_request(c, pick_key(), $urandom_range(9) != 0,
                     ($urandom_range(19) == 0) ? SIZE_W'($urandom)
                                               : SIZE_W'($urandom_range(size_max)));
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_cmd = '0; req_key = '0; req_load_ok = 0; req_load_bytes = '0;
      rsp_stall = 0; csr_valid = 0; csr_data = '0;
      fail_count = 0; idle_enable = 1; sender_hold = 0; rsp_hold_cycles = 0;
      req_taken = 0;
      budget = '0;
      foreach (shadow_valid[i]) shadow_valid[i] = 0;
      shadow_total = 0; shadow_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // zero budget: a load of nonzero size is dropped at once, a zero-byte load stays
      add_request(CMD_ENSURE, 16'h0001, 1, 24'd5);
      add_request(CMD_ENSURE, 16'h0002, 1, 24'd0);
      add_request(CMD_ENSURE, 16'h0002, 1, 24'd0);
      drain();

      // full budget: fill the table, then overflow it
      set_budget('1);
      for (int i = 0; i < 17; i++)
         add_request(CMD_ENSURE, KEY_W'(i), 1, (i == 3) ? '1 : SIZE_W'(i + 1));
      add_request(CMD_ENSURE, 16'hFFFF, 0, 24'd9);
      add_request(CMD_ENSURE, 16'h0005, 1, 24'd0);
      add_request(CMD_REMOVE, 16'h0005, 0, 24'd0);
      add_request(CMD_REMOVE, 16'h0005, 1, '1);
      add_request(CMD_QUERY, 16'h0006, 0, 24'd0);
      add_request(2'd3, 16'hFFFF, 1, '1);
      drain();

      // lowered budget takes effect only at the next insert
      set_budget(32'd40);
      add_request(CMD_QUERY, 16'h0007, 0, 24'd0);
      add_request(CMD_ENSURE, 16'h0100, 1, 24'd30);
      drain();

      // random mix, long stretch without idling
      set_budget(32'd200);
      idle_enable = 0;
      add_random(50, 60);
      drain();
      idle_enable = 1;
      set_budget(32'hFFFF_FFFF);
      add_random(30, 60);

      // receiver holds off while the sender keeps offering
      @(negedge clock);
      rsp_hold_cycles <= 300;
      drain();

      // sender pauses until all results are in, then resumes
      set_budget(32'd1000);
      add_random(20, 300);
      sender_hold = 1;
      while (expected_outcomes.size() > 0 || req_valid) @(posedge clock);
      repeat (60) @(posedge clock);
      sender_hold = 0;
      drain();
      set_budget(32'd0);
      add_random(10, 40);
      drain();
      set_budget(32'h00FF_FFFF);
      add_random(40, 1 << 22);
      drain();

      if (fail_count == 0)
         $display("PASS byte_budget_lru_cache_unit");
      else
         $display("FAIL byte_budget_lru_cache_unit");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL byte_budget_lru_cache_unit");
      $finish;
   end

endmodule
